// ----- rtl/bhcd_pkg.sv -----
// bhcd_pkg: shared widths, offsets, command and result types for the
// button and hat change detector. No dependencies.

package bhcd_pkg;

	localparam int OFS_W  = 9;
	localparam int DATA_W = 32;
	localparam int STEP_W = 16;
	localparam int IDX_W  = 8;
	localparam int BTN_W  = 7;
	localparam int HAT_W  = 2;
	localparam int DIR_W  = 4;

	localparam logic [OFS_W-1:0]  HAT_BASE_OFFSET    = 9'd32;
	localparam logic [OFS_W-1:0]  BUTTON_BASE_OFFSET = 9'd48;
	localparam int                PRESS_BIT          = 7;
	localparam logic [STEP_W-1:0] HAT_STEP_RESET     = 16'd4500;

	typedef enum logic {
		CMD_HAT,
		CMD_BUTTON
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BTN_W-1:0]  sel;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] control_index;
		logic             pressed;
		logic             last_change;
	} res_t;

endpackage

// ----- rtl/bhcd_front.sv -----
// bhcd_front: accepts events, classifies the offset as hat or button,
// drops the rest, and queues commands for the back end. Uses bhcd_pkg.

module bhcd_front #(
	parameter int BUTTONS = 128,
	parameter int HATS    = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [bhcd_pkg::OFS_W-1:0] event_offset,
	input  logic [bhcd_pkg::DATA_W-1:0] event_data,
	output logic                       full,
	output logic                       cmd_valid,
	output bhcd_pkg::cmd_t             cmd,
	input  logic                       cmd_pop
);

	logic [bhcd_pkg::HAT_W-1:0] hat_num;
	logic [bhcd_pkg::OFS_W-1:0] btn_rel;
	logic                       is_hat;
	logic                       is_btn;
	logic                       cq_wr;
	logic                       cq_rd;
	bhcd_pkg::cmd_t             cq_new;
	bhcd_pkg::cmd_t             cq_q [2];
	logic                       cq_wp_q;
	logic                       cq_rp_q;
	logic [1:0]                 cq_cnt_q;

	assign hat_num = event_offset[3:2];
	assign is_hat  = (event_offset[bhcd_pkg::OFS_W-1:4] ==
	                  bhcd_pkg::HAT_BASE_OFFSET[bhcd_pkg::OFS_W-1:4]) &&
	                 (event_offset[1:0] == 2'b00) &&
	                 ({1'b0, hat_num} < 3'(HATS));
	assign btn_rel = event_offset - bhcd_pkg::BUTTON_BASE_OFFSET;
	assign is_btn  = (event_offset >= bhcd_pkg::BUTTON_BASE_OFFSET) &&
	                 (btn_rel < bhcd_pkg::OFS_W'(BUTTONS));

	always_comb begin
		cq_new.kind = is_hat ? bhcd_pkg::CMD_HAT : bhcd_pkg::CMD_BUTTON;
		cq_new.sel  = is_hat ? bhcd_pkg::BTN_W'(hat_num) : btn_rel[bhcd_pkg::BTN_W-1:0];
		cq_new.data = event_data;
	end

	assign full      = (cq_cnt_q == 2'd2);
	assign cmd_valid = (cq_cnt_q != 2'd0);
	assign cmd       = cq_q[cq_rp_q];
	assign cq_wr     = push && !full && (is_hat || is_btn);
	assign cq_rd     = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wp_q  <= 1'b0;
			cq_rp_q  <= 1'b0;
			cq_cnt_q <= 2'd0;
		end else begin
			if (cq_wr) begin
				cq_wp_q <= !cq_wp_q;
			end
			if (cq_rd) begin
				cq_rp_q <= !cq_rp_q;
			end
			if (cq_wr && !cq_rd) begin
				cq_cnt_q <= cq_cnt_q + 2'd1;
			end else if (!cq_wr && cq_rd) begin
				cq_cnt_q <= cq_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cq_wr) begin
			cq_q[cq_wp_q] <= cq_new;
		end
	end

endmodule

// ----- rtl/bhcd_div.sv -----
// bhcd_div: restoring divider, one quotient bit per cycle, for the hat
// angle over the step size. Uses bhcd_pkg.

module bhcd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bhcd_pkg::DATA_W-1:0] dividend,
	input  logic [bhcd_pkg::STEP_W-1:0] divisor,
	output logic                        done,
	output logic [bhcd_pkg::DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(bhcd_pkg::DATA_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [bhcd_pkg::STEP_W-1:0] rem_q;
	logic [bhcd_pkg::STEP_W-1:0] dvs_q;
	logic [bhcd_pkg::DATA_W-1:0] quo_q;
	logic [bhcd_pkg::STEP_W:0]   trial;
	logic [bhcd_pkg::STEP_W:0]   diff;
	logic                        ge;

	assign trial = {rem_q, quo_q[bhcd_pkg::DATA_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= ge ? diff[bhcd_pkg::STEP_W-1:0] : trial[bhcd_pkg::STEP_W-1:0];
				quo_q <= {quo_q[bhcd_pkg::DATA_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(bhcd_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/bhcd_back.sv -----
// bhcd_back: executes queued commands against the pressed map, runs the
// hat divider, and queues the change items. Uses bhcd_pkg, bhcd_div.

module bhcd_back #(
	parameter int BUTTONS        = 128,
	parameter int HAT_DIRECTIONS = 8,
	parameter int HATS           = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bhcd_pkg::STEP_W-1:0] hat_step,
	input  logic                        cmd_valid,
	input  bhcd_pkg::cmd_t              cmd,
	output logic                        cmd_pop,
	output logic                        empty,
	input  logic                        pop,
	output bhcd_pkg::res_t              res
);

	localparam int MAP_SIZE = BUTTONS + HATS * HAT_DIRECTIONS;
	localparam int MAP_W    = $clog2(MAP_SIZE);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                      st_q;
	logic [MAP_SIZE-1:0]         map_q;
	logic [bhcd_pkg::HAT_W-1:0]  hat_q;
	bhcd_pkg::res_t              res0_q;
	bhcd_pkg::res_t              res1_q;
	logic [1:0]                  nres_q;
	logic                        ei_q;

	logic                        div_start;
	logic                        div_done;
	logic [bhcd_pkg::DATA_W-1:0] quotient;

	logic [HAT_DIRECTIONS-1:0]   old_bits;
	logic [HAT_DIRECTIONS-1:0]   new_bits;
	logic [bhcd_pkg::DIR_W-1:0]  old_pos;
	logic [bhcd_pkg::DIR_W-1:0]  new_pos;
	logic                        old_any;
	logic                        new_any;
	logic                        do_clr;
	logic                        do_set;
	logic [bhcd_pkg::IDX_W-1:0]  hat_base;
	logic [bhcd_pkg::IDX_W-1:0]  idx_clr;
	logic [bhcd_pkg::IDX_W-1:0]  idx_set;
	bhcd_pkg::res_t              hat_r0;
	bhcd_pkg::res_t              hat_r1;
	logic [1:0]                  hat_n;
	logic                        btn_old;
	logic                        btn_new;

	bhcd_pkg::res_t              rf_q [2];
	logic                        rf_wp_q;
	logic                        rf_rp_q;
	logic [1:0]                  rf_cnt_q;
	logic                        rf_full;
	logic                        rf_wr;
	logic                        rf_rd;

	bhcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd.data),
		.divisor  (hat_step),
		.done     (div_done),
		.quotient (quotient)
	);

	assign cmd_pop   = (st_q == ST_IDLE) && cmd_valid;
	assign div_start = cmd_pop && (cmd.kind == bhcd_pkg::CMD_HAT);

	// hat slice of the map and its one-hot position
	always_comb begin
		old_bits = '0;
		for (int h = 0; h < HATS; h++) begin
			if (hat_q == bhcd_pkg::HAT_W'(h)) begin
				old_bits = map_q[BUTTONS + h * HAT_DIRECTIONS +: HAT_DIRECTIONS];
			end
		end
		old_pos = '0;
		for (int j = 0; j < HAT_DIRECTIONS; j++) begin
			if (old_bits[j]) begin
				old_pos = old_pos | bhcd_pkg::DIR_W'(j);
			end
		end
		old_any = |old_bits;
		new_any = (quotient < bhcd_pkg::DATA_W'(HAT_DIRECTIONS));
		new_pos = quotient[bhcd_pkg::DIR_W-1:0];
		for (int j = 0; j < HAT_DIRECTIONS; j++) begin
			new_bits[j] = new_any && (new_pos == bhcd_pkg::DIR_W'(j));
		end
	end

	assign hat_base = bhcd_pkg::IDX_W'(BUTTONS + int'(hat_q) * HAT_DIRECTIONS);
	assign idx_clr  = hat_base + bhcd_pkg::IDX_W'(old_pos);
	assign idx_set  = hat_base + bhcd_pkg::IDX_W'(new_pos);
	assign do_clr   = old_any && !(new_any && (old_pos == new_pos));
	assign do_set   = new_any && !(old_any && (old_pos == new_pos));

	// ascending index order
	always_comb begin
		hat_r0 = '0;
		hat_r1 = '0;
		hat_n  = 2'd0;
		if (do_clr && do_set) begin
			hat_n = 2'd2;
			if (old_pos < new_pos) begin
				hat_r0 = '{control_index: idx_clr, pressed: 1'b0, last_change: 1'b0};
				hat_r1 = '{control_index: idx_set, pressed: 1'b1, last_change: 1'b1};
			end else begin
				hat_r0 = '{control_index: idx_set, pressed: 1'b1, last_change: 1'b0};
				hat_r1 = '{control_index: idx_clr, pressed: 1'b0, last_change: 1'b1};
			end
		end else if (do_clr) begin
			hat_n  = 2'd1;
			hat_r0 = '{control_index: idx_clr, pressed: 1'b0, last_change: 1'b1};
		end else if (do_set) begin
			hat_n  = 2'd1;
			hat_r0 = '{control_index: idx_set, pressed: 1'b1, last_change: 1'b1};
		end
	end

	assign btn_old = map_q[MAP_W'(cmd.sel)];
	assign btn_new = cmd.data[bhcd_pkg::PRESS_BIT];

	assign rf_full = (rf_cnt_q == 2'd2);
	assign rf_wr   = (st_q == ST_EMIT) && !rf_full;
	assign rf_rd   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			map_q  <= '0;
			hat_q  <= '0;
			res0_q <= '0;
			res1_q <= '0;
			nres_q <= 2'd0;
			ei_q   <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == bhcd_pkg::CMD_HAT) begin
							hat_q <= cmd.sel[bhcd_pkg::HAT_W-1:0];
							st_q  <= ST_DIV;
						end else if (btn_old != btn_new) begin
							map_q[MAP_W'(cmd.sel)] <= btn_new;
							res0_q <= '{control_index: bhcd_pkg::IDX_W'(cmd.sel),
							           pressed: btn_new, last_change: 1'b1};
							nres_q <= 2'd1;
							ei_q   <= 1'b0;
							st_q   <= ST_EMIT;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						for (int h = 0; h < HATS; h++) begin
							if (hat_q == bhcd_pkg::HAT_W'(h)) begin
								map_q[BUTTONS + h * HAT_DIRECTIONS +: HAT_DIRECTIONS] <= new_bits;
							end
						end
						res0_q <= hat_r0;
						res1_q <= hat_r1;
						nres_q <= hat_n;
						ei_q   <= 1'b0;
						st_q   <= (hat_n == 2'd0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!rf_full) begin
						if (ei_q || (nres_q == 2'd1)) begin
							st_q <= ST_IDLE;
						end else begin
							ei_q <= 1'b1;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_wp_q  <= 1'b0;
			rf_rp_q  <= 1'b0;
			rf_cnt_q <= 2'd0;
		end else begin
			if (rf_wr) begin
				rf_wp_q <= !rf_wp_q;
			end
			if (rf_rd) begin
				rf_rp_q <= !rf_rp_q;
			end
			if (rf_wr && !rf_rd) begin
				rf_cnt_q <= rf_cnt_q + 2'd1;
			end else if (!rf_wr && rf_rd) begin
				rf_cnt_q <= rf_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rf_wr) begin
			rf_q[rf_wp_q] <= ei_q ? res1_q : res0_q;
		end
	end

	assign empty = (rf_cnt_q == 2'd0);
	assign res   = rf_q[rf_rp_q];

	ap_emit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> (nres_q != 2'd0))
		else $error("emit state with no pending item");

	ap_hat_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(old_bits))
		else $error("hat holds more than one active direction");

	ap_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIV))
		else $error("divider finished outside of divide state");

	ap_rf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rf_cnt_q != 2'd3)
		else $error("result queue count overflow");

endmodule

// ----- rtl/button_hat_change_detector.sv -----
// button_hat_change_detector: top level, holds the hat step register and
// joins the front classifier and back executor. Uses bhcd_pkg, bhcd_front, bhcd_back.
//
// channel   direction  handshake           payload
// event     in         push / full         event_offset, event_data
// change    out        pop / empty         control_index, pressed, last_change
// config    in         hat_step_we         hat_step
//
// a changed button passes the emit state into the result queue; an unchanged one queues nothing.
// a hat item runs the bit-serial divider, then updates the map and queues up to two changes.
// the front queues two commands and the result queue holds two items, so each side stalls alone.
// reset clears the pressed map, both queues, and loads hat_step with 4500.

module button_hat_change_detector #(
	parameter int BUTTONS        = 128,
	parameter int HAT_DIRECTIONS = 8,
	parameter int HATS           = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [bhcd_pkg::OFS_W-1:0]  event_offset,
	input  logic [bhcd_pkg::DATA_W-1:0] event_data,
	output logic                        empty,
	input  logic                        pop,
	output logic [bhcd_pkg::IDX_W-1:0]  control_index,
	output logic                        pressed,
	output logic                        last_change,
	input  logic                        hat_step_we,
	input  logic [bhcd_pkg::STEP_W-1:0] hat_step
);

	logic [bhcd_pkg::STEP_W-1:0] hat_step_q;
	logic                        cmd_valid;
	logic                        cmd_pop;
	bhcd_pkg::cmd_t              cmd;
	bhcd_pkg::res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hat_step_q <= bhcd_pkg::HAT_STEP_RESET;
		end else if (hat_step_we) begin
			hat_step_q <= hat_step;
		end
	end

	bhcd_front #(
		.BUTTONS (BUTTONS),
		.HATS    (HATS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.event_offset (event_offset),
		.event_data   (event_data),
		.full         (full),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	bhcd_back #(
		.BUTTONS        (BUTTONS),
		.HAT_DIRECTIONS (HAT_DIRECTIONS),
		.HATS           (HATS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.hat_step  (hat_step_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign control_index = res.control_index;
	assign pressed       = res.pressed;
	assign last_change   = res.last_change;

endmodule

// ----- verif/button_hat_change_detector_test.sv -----
// button_hat_change_detector_test: self-checking bench for the button and hat change detector.
// a scoreboard class tracks the pressed map and hat step and predicts each change; uses bhcd_pkg
// and drives button_hat_change_detector with random bursts, receiver stalls and hat step settings.

module button_hat_change_detector_test;

	localparam int BUTTONS        = 128;
	localparam int HAT_DIRECTIONS = 8;
	localparam int HATS           = 4;
	localparam int CONTROLS       = BUTTONS + HATS * HAT_DIRECTIONS;
	localparam int SETTLE_CYCLES  = 256;
	localparam int HOLD_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PHASE_ITEMS    = 80;

	typedef enum {
		POP_ALWAYS,
		POP_HALF,
		POP_RARE
	} pop_mode_t;

	class scoreboard_t;
		logic [bhcd_pkg::STEP_W-1:0] step;
		bit                          pressed_bits[CONTROLS];
		bhcd_pkg::res_t              expected_changes[$];
		int                          mismatches;

		function new();
			step = bhcd_pkg::HAT_STEP_RESET;
			foreach (pressed_bits[i])
				pressed_bits[i] = 1'b0;
			mismatches = 0;
		endfunction

		function void set_step(logic [bhcd_pkg::STEP_W-1:0] v);
			step = v;
		endfunction

		function int outstanding();
			return expected_changes.size();
		endfunction

		function void note_event(logic [bhcd_pkg::OFS_W-1:0] ofs,
				logic [bhcd_pkg::DATA_W-1:0] data);
			bhcd_pkg::res_t              found[$];
			bhcd_pkg::res_t              r;
			int                          o;
			int                          hat_no;
			int                          idx;
			bit                          nv;
			logic [bhcd_pkg::DATA_W-1:0] pos;
			o = ofs;
			if (o >= bhcd_pkg::HAT_BASE_OFFSET && o < bhcd_pkg::HAT_BASE_OFFSET + 16 &&
					ofs[1:0] == 2'b00) begin
				hat_no = (o - bhcd_pkg::HAT_BASE_OFFSET) >> 2;
				if (hat_no < HATS) begin
					pos = (step == '0) ? '1 : data / {16'd0, step};
					for (int j = 0; j < HAT_DIRECTIONS; j++) begin
						idx = BUTTONS + hat_no * HAT_DIRECTIONS + j;
						nv = (pos == bhcd_pkg::DATA_W'(j));
						if (idx < CONTROLS && pressed_bits[idx] != nv) begin
							pressed_bits[idx] = nv;
							if (found.size() < 2) begin
								r.control_index = bhcd_pkg::IDX_W'(idx);
								r.pressed = nv;
								r.last_change = 1'b0;
								found.insert(found.size(), r);
							end
						end
					end
				end
			end else if (o >= bhcd_pkg::BUTTON_BASE_OFFSET &&
					o < bhcd_pkg::BUTTON_BASE_OFFSET + BUTTONS) begin
				idx = o - bhcd_pkg::BUTTON_BASE_OFFSET;
				nv = data[bhcd_pkg::PRESS_BIT];
				if (pressed_bits[idx] != nv) begin
					pressed_bits[idx] = nv;
					r.control_index = bhcd_pkg::IDX_W'(idx);
					r.pressed = nv;
					r.last_change = 1'b0;
					found.insert(found.size(), r);
				end
			end
			if (found.size() > 0)
				found[found.size()-1].last_change = 1'b1;
			foreach (found[i])
				expected_changes.insert(expected_changes.size(), found[i]);
		endfunction

		function void check_change(bhcd_pkg::res_t got);
			bhcd_pkg::res_t exp_r;
			if (expected_changes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected change: index %0d pressed %0b last %0b",
						got.control_index, got.pressed, got.last_change);
				return;
			end
			exp_r = expected_changes.pop_front();
			if (got.control_index !== exp_r.control_index || got.pressed !== exp_r.pressed ||
					got.last_change !== exp_r.last_change) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected index %0d pressed %0b last %0b, ",
						"got index %0d pressed %0b last %0b"},
						exp_r.control_index, exp_r.pressed, exp_r.last_change,
						got.control_index, got.pressed, got.last_change);
			end
		endfunction
	endclass

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        push         = 1'b0;
	logic                        full;
	logic [bhcd_pkg::OFS_W-1:0]  event_offset = '0;
	logic [bhcd_pkg::DATA_W-1:0] event_data   = '0;
	logic                        empty;
	logic                        pop          = 1'b0;
	logic [bhcd_pkg::IDX_W-1:0]  control_index;
	logic                        pressed;
	logic                        last_change;
	logic                        hat_step_we  = 1'b0;
	logic [bhcd_pkg::STEP_W-1:0] hat_step     = bhcd_pkg::HAT_STEP_RESET;

	bit                          hold_req     = 1'b0;
	int                          cycles       = 0;
	scoreboard_t                 sb           = new();

	button_hat_change_detector #(
		.BUTTONS        (BUTTONS),
		.HAT_DIRECTIONS (HAT_DIRECTIONS),
		.HATS           (HATS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.event_offset  (event_offset),
		.event_data    (event_data),
		.empty         (empty),
		.pop           (pop),
		.control_index (control_index),
		.pressed       (pressed),
		.last_change   (last_change),
		.hat_step_we   (hat_step_we),
		.hat_step      (hat_step)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// receiver: stall pattern of its own, plus one long hold-off on request
	initial begin
		pop_mode_t      mode;
		int             mode_left;
		int             hold_left;
		bhcd_pkg::res_t got;
		mode = POP_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.control_index = control_index;
				got.pressed = pressed;
				got.last_change = last_change;
				sb.check_change(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = pop_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					POP_ALWAYS: pop <= 1'b1;
					POP_HALF:   pop <= 1'($urandom_range(0, 1));
					default:    pop <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	task automatic send_event(input logic [bhcd_pkg::OFS_W-1:0] ofs,
			input logic [bhcd_pkg::DATA_W-1:0] data);
		push <= 1'b1;
		event_offset <= ofs;
		event_data <= data;
		do
			@(posedge clk);
		while (full);
		sb.note_event(ofs, data);
	endtask

	task automatic write_step(input logic [bhcd_pkg::STEP_W-1:0] v);
		hat_step_we <= 1'b1;
		hat_step <= v;
		@(posedge clk);
		hat_step_we <= 1'b0;
		sb.set_step(v);
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// returns 1 when the event selects a hat or a button
	function automatic bit make_event(output logic [bhcd_pkg::OFS_W-1:0] ofs,
			output logic [bhcd_pkg::DATA_W-1:0] data);
		int                          pick;
		int                          hat_no;
		logic [bhcd_pkg::DATA_W-1:0] s;
		pick = $urandom_range(0, 99);
		s = {16'd0, sb.step};
		if (pick < 40) begin
			hat_no = $urandom_range(0, HATS - 1);
			ofs = bhcd_pkg::HAT_BASE_OFFSET + bhcd_pkg::OFS_W'(4 * hat_no);
			if (s == '0)
				data = $urandom;
			else
				data = bhcd_pkg::DATA_W'($urandom_range(0, HAT_DIRECTIONS)) * s +
					($urandom % s);
			return 1'b1;
		end else if (pick < 50) begin
			ofs = bhcd_pkg::HAT_BASE_OFFSET +
				bhcd_pkg::OFS_W'(4 * $urandom_range(0, HATS - 1));
			data = '1;
			return 1'b1;
		end else if (pick < 85) begin
			if ($urandom_range(0, 1))
				ofs = bhcd_pkg::BUTTON_BASE_OFFSET + bhcd_pkg::OFS_W'($urandom_range(0, 7));
			else
				ofs = bhcd_pkg::BUTTON_BASE_OFFSET +
					bhcd_pkg::OFS_W'($urandom_range(0, BUTTONS - 1));
			data = $urandom;
			return 1'b1;
		end
		ofs = bhcd_pkg::OFS_W'($urandom_range(0, 511));
		data = $urandom;
		return ((ofs >= bhcd_pkg::HAT_BASE_OFFSET && ofs < bhcd_pkg::HAT_BASE_OFFSET + 16 &&
			ofs[1:0] == 2'b00) || (ofs >= bhcd_pkg::BUTTON_BASE_OFFSET &&
			ofs < bhcd_pkg::BUTTON_BASE_OFFSET + BUTTONS));
	endfunction

	task automatic run_random(input int count, input bit hold_mid, input bit drain_mid);
		int                          counted;
		int                          burst;
		logic [bhcd_pkg::OFS_W-1:0]  ofs;
		logic [bhcd_pkg::DATA_W-1:0] data;
		counted = 0;
		burst = $urandom_range(1, 32);
		while (counted < count) begin
			if (make_event(ofs, data))
				counted++;
			send_event(ofs, data);
			if (hold_mid && counted == count / 4)
				hold_req = 1'b1;
			if (drain_mid && counted == count / 2) begin
				drain_mid = 1'b0;
				push <= 1'b0;
				@(posedge clk);
				while (sb.outstanding() != 0)
					@(posedge clk);
			end else begin
				burst--;
				if (burst == 0) begin
					push <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
					burst = $urandom_range(1, 32);
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_step(bhcd_pkg::HAT_STEP_RESET);

		// directed: buttons at both ends, hats across directions, ignored offsets
		send_event(bhcd_pkg::BUTTON_BASE_OFFSET, 32'h0000_0080);
		send_event(bhcd_pkg::BUTTON_BASE_OFFSET, 32'h0000_0080);
		send_event(bhcd_pkg::BUTTON_BASE_OFFSET + bhcd_pkg::OFS_W'(BUTTONS - 1), 32'hFFFF_FFFF);
		send_event(bhcd_pkg::BUTTON_BASE_OFFSET, 32'hFFFF_FF7F);
		send_event(bhcd_pkg::BUTTON_BASE_OFFSET + bhcd_pkg::OFS_W'(BUTTONS - 1), 32'h0000_0000);
		send_event(bhcd_pkg::BUTTON_BASE_OFFSET + 9'd52, 32'h0000_0080);
		send_event(bhcd_pkg::HAT_BASE_OFFSET, 32'd0);
		send_event(bhcd_pkg::HAT_BASE_OFFSET, 32'd4500);
		send_event(bhcd_pkg::HAT_BASE_OFFSET, 32'hFFFF_FFFF);
		send_event(bhcd_pkg::HAT_BASE_OFFSET + 9'd12, 32'd35999);
		send_event(bhcd_pkg::HAT_BASE_OFFSET + 9'd12, 32'd36000);
		send_event(bhcd_pkg::HAT_BASE_OFFSET + 9'd4, 32'hFFFF_FFFF);
		send_event(bhcd_pkg::HAT_BASE_OFFSET + 9'd8, 32'd4499);
		send_event(bhcd_pkg::HAT_BASE_OFFSET + 9'd8, 32'd4499);
		send_event(bhcd_pkg::HAT_BASE_OFFSET + 9'd1, 32'd0);
		send_event(9'd47, 32'h0000_0080);
		send_event(9'd31, 32'd0);
		send_event(9'd0, 32'hFFFF_FFFF);
		send_event(bhcd_pkg::BUTTON_BASE_OFFSET + bhcd_pkg::OFS_W'(BUTTONS), 32'h0000_0080);
		send_event(9'd511, 32'hFFFF_FFFF);
		settle();

		run_random(PHASE_ITEMS, 1'b0, 1'b0);
		settle();
		write_step(16'd1);
		run_random(PHASE_ITEMS, 1'b1, 1'b0);
		settle();
		write_step(16'hFFFF);
		run_random(PHASE_ITEMS, 1'b0, 1'b1);
		settle();
		write_step(16'd0);
		send_event(bhcd_pkg::HAT_BASE_OFFSET, 32'd0);
		send_event(bhcd_pkg::HAT_BASE_OFFSET + 9'd8, 32'hFFFF_FFFF);
		run_random(PHASE_ITEMS / 2, 1'b0, 1'b0);
		settle();
		write_step(bhcd_pkg::STEP_W'($urandom_range(2, 65534)));
		run_random(PHASE_ITEMS, 1'b0, 1'b0);
		settle();

		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/bhcd_pkg.sv
rtl/bhcd_front.sv
rtl/bhcd_div.sv
rtl/bhcd_back.sv
rtl/button_hat_change_detector.sv
verif/button_hat_change_detector_test.sv
